FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/fprb_pkg.sv
// ---------------------------------------------------------------------------
// fprb_pkg
// Widths, limits, register indexes and row modes of the ramp blend core.
// ---------------------------------------------------------------------------
package fprb_pkg;

  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_ROW_BYTES = 8192;

  localparam int BYTE_W      = 8;
  localparam int CUTOFF_W    = 13;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_BYTES_W = 14;
  localparam int COUNT_W     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;

  // Ramp span and rounding of the blend.
  localparam int RAMP_SPAN   = 31;
  localparam int RAMP_ROUND  = 16;
  localparam int RAMP_SHIFT  = 5;
  localparam int DIST_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 2'd2;

  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET    = 13'd480;
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd1440;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_COPY,
    MODE_BLEND
  } mode_t;

endpackage

FILE: hw/rtl/frame_pair_ramp_blend_core.sv
// ---------------------------------------------------------------------------
// frame_pair_ramp_blend_core
// Raster-order byte pair blender: copy, ramp blend or pass per row.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one co-sited byte pair per
//   request: main byte of the current frame, other byte of the next frame,
//   and frame_start on the first byte of a frame (clears the counters
//   before that byte is placed).
//   Output channel (out_valid / out_stall) returns one request per input:
//   the result byte and frame_last on the final byte of the frame.
//   Config channel (cfg_valid / cfg_ready, always ready) writes cutoff,
//   frame_height and row_bytes by index; write only while the core is idle.
//   Throughput: one request per clock while out_stall is low, set by the
//   two-register pipeline (input stage holds position decode, output
//   stage captures the 9x6 multiply and round). A request passes the
//   input stage register and then the output register to out_valid.
//   Stall: out_stall on a full output register holds it; once the input
//   stage also holds a request, in_stall rises; no request is dropped.
//   Reset (rst_n low, synchronous): pipeline empty, counters at 0,
//   cutoff 0, frame_height 480, row_bytes 1440.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_pair_ramp_blend_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fprb_pkg::BYTE_W-1:0]       in_main_byte,
  input  logic [fprb_pkg::BYTE_W-1:0]       in_other_byte,
  input  logic                              in_frame_start,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fprb_pkg::BYTE_W-1:0]       out_result_byte,
  output logic                              out_frame_last,
  // config channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fprb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fprb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // config registers
  logic [fprb_pkg::CUTOFF_W-1:0]    cutoff_r;
  logic [fprb_pkg::HEIGHT_W-1:0]    height_r;
  logic [fprb_pkg::ROW_BYTES_W-1:0] row_bytes_r;

  // position counters
  logic [fprb_pkg::COUNT_W-1:0] col_r, col_nxt;
  logic [fprb_pkg::COUNT_W-1:0] row_r, row_nxt;

  // stage 1: decoded request
  logic                          s1_valid_r;
  logic [fprb_pkg::BYTE_W-1:0]   s1_main_r;
  logic [fprb_pkg::BYTE_W-1:0]   s1_other_r;
  fprb_pkg::mode_t               s1_mode_r;
  logic [fprb_pkg::DIST_W-1:0]   s1_dist_r;
  logic                          s1_last_r;

  // stage 2: result register
  logic                          out_valid_r;
  logic [fprb_pkg::BYTE_W-1:0]   out_result_r;
  logic                          out_last_r;

  logic in_acc;
  logic s1_adv;

  // effective dimensions: zero acts as one, large values saturate
  logic [fprb_pkg::HEIGHT_W-1:0]    h_eff;
  logic [fprb_pkg::ROW_BYTES_W-1:0] rb_eff;

  // position of the byte in flight
  logic [fprb_pkg::COUNT_W-1:0] col_cur, row_cur;
  logic [fprb_pkg::COUNT_W:0]   row_p31;
  logic                         row_end, frame_end;
  logic                         is_copy, is_blend;
  fprb_pkg::mode_t              mode_cur;
  logic [fprb_pkg::DIST_W-1:0]  dist_cur;

  // blend datapath
  logic signed [fprb_pkg::BYTE_W:0]     diff;
  logic signed [fprb_pkg::DIST_W:0]     dist_s;
  logic signed [14:0]                   blend_t;
  logic signed [14:0]                   blend_q;
  logic [fprb_pkg::BYTE_W-1:0]          result_nxt;

  // --- handshake ----------------------------------------------------------
  // Output register frees when empty or taken this cycle; the input stage
  // moves whenever the output register can take it.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // --- dimensions ---------------------------------------------------------
  always_comb begin
    if (height_r == '0) begin
      h_eff = fprb_pkg::HEIGHT_W'(1);
    end else if (height_r > fprb_pkg::HEIGHT_W'(fprb_pkg::MAX_HEIGHT)) begin
      h_eff = fprb_pkg::HEIGHT_W'(fprb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    if (row_bytes_r == '0) begin
      rb_eff = fprb_pkg::ROW_BYTES_W'(1);
    end else if (row_bytes_r > fprb_pkg::ROW_BYTES_W'(fprb_pkg::MAX_ROW_BYTES)) begin
      rb_eff = fprb_pkg::ROW_BYTES_W'(fprb_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = row_bytes_r;
    end
  end

  // --- position and row decode --------------------------------------------
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? '0 : row_r;

    // counters past the end (dims shrunk) also end the row / frame
    row_end   = ({1'b0, col_cur} + 14'd1) >= rb_eff;
    frame_end = row_end && (({1'b0, row_cur} + 14'd1) >= {1'b0, h_eff});

    if (row_end) begin
      col_nxt = '0;
      row_nxt = frame_end ? '0 : row_cur + 13'd1;
    end else begin
      col_nxt = col_cur + 13'd1;
      row_nxt = row_cur;
    end

    // copy: row < cutoff-31 and row < height
    // blend: cutoff-31 <= row < cutoff, and not on the last frame row
    row_p31  = {1'b0, row_cur} + 14'(fprb_pkg::RAMP_SPAN);
    is_copy  = (row_p31 < {1'b0, cutoff_r}) && (row_cur < h_eff);
    is_blend = (row_p31 >= {1'b0, cutoff_r}) && (row_cur < cutoff_r)
            && (({1'b0, row_cur} + 14'd1) < {1'b0, h_eff});

    if (is_copy) begin
      mode_cur = fprb_pkg::MODE_COPY;
    end else if (is_blend) begin
      mode_cur = fprb_pkg::MODE_BLEND;
    end else begin
      mode_cur = fprb_pkg::MODE_PASS;
    end

    // ramp weight cutoff-row is 1..31 inside the blend band
    dist_cur = fprb_pkg::DIST_W'(cutoff_r - row_cur);
  end

  // --- blend: main + ((other-main)*w + 16) >>> 5 --------------------------
  always_comb begin
    diff    = $signed({1'b0, s1_other_r}) - $signed({1'b0, s1_main_r});
    dist_s  = $signed({1'b0, s1_dist_r});
    blend_t = 15'(diff) * 15'(dist_s) + 15'sd16;
    blend_q = blend_t >>> fprb_pkg::RAMP_SHIFT;
    case (s1_mode_r)
      fprb_pkg::MODE_COPY:  result_nxt = s1_other_r;
      fprb_pkg::MODE_BLEND: result_nxt = s1_main_r + blend_q[fprb_pkg::BYTE_W-1:0];
      default:              result_nxt = s1_main_r;
    endcase
  end

  // --- config registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= '0;
      height_r    <= fprb_pkg::HEIGHT_RESET;
      row_bytes_r <= fprb_pkg::ROW_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fprb_pkg::CFG_CUTOFF:       cutoff_r    <= cfg_data[fprb_pkg::CUTOFF_W-1:0];
        fprb_pkg::CFG_FRAME_HEIGHT: height_r    <= cfg_data[fprb_pkg::HEIGHT_W-1:0];
        fprb_pkg::CFG_ROW_BYTES:    row_bytes_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- counters and pipeline control --------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // --- payload registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_main_r  <= in_main_byte;
      s1_other_r <= in_other_byte;
      s1_mode_r  <= mode_cur;
      s1_dist_r  <= dist_cur;
      s1_last_r  <= frame_end;
    end
    if (s1_adv && s1_valid_r) begin
      out_result_r <= result_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_result_r;
  assign out_frame_last  = out_last_r;

  // --- assertions ---------------------------------------------------------
  `ASSERT_IMPLIES(a_stall_needs_full, in_stall, s1_valid_r)
  `ASSERT_IMPLIES(a_blend_weight, s1_valid_r && (s1_mode_r == fprb_pkg::MODE_BLEND),
                  s1_dist_r != '0)
  `ASSERT_IMPLIES(a_out_from_stage1, $rose(out_valid_r), $past(s1_valid_r))
  `ASSERT_NEXT(a_start_clears, in_acc && in_frame_start && (rb_eff > 14'd1)
               && $stable(row_bytes_r), col_r == 13'd1)

endmodule
